// ===== rtl/cdt_pkg.sv =====
// Package for the countdown timer with display.
// Holds the configuration register indexes, reset values, the seven-segment
// table and the reciprocal constants for digit extraction. No dependencies.
package cdt_pkg;

  localparam int RemainWidth = 14;
  localparam int RecipShift  = 28;
  localparam int RecipWidth  = 25;
  localparam int ProdWidth   = RemainWidth + RecipWidth;

  localparam logic [2:0] CFG_TICKS_PER_KEY_SAMPLE = 3'd0;
  localparam logic [2:0] CFG_TICKS_PER_STEP       = 3'd1;
  localparam logic [2:0] CFG_STEPS_PER_SECOND     = 3'd2;
  localparam logic [2:0] CFG_STEPS_PER_BLINK      = 3'd3;
  localparam logic [2:0] CFG_MAX_SETTING          = 3'd4;

  localparam logic [3:0]             RST_TICKS_PER_KEY_SAMPLE = 4'd4;
  localparam logic [7:0]             RST_TICKS_PER_STEP       = 8'd10;
  localparam logic [7:0]             RST_STEPS_PER_SECOND     = 8'd20;
  localparam logic [7:0]             RST_STEPS_PER_BLINK      = 8'd10;
  localparam logic [RemainWidth-1:0] RST_MAX_SETTING          = 14'd9999;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_EIGHT = 8'h80;

  typedef struct packed {
    logic [RemainWidth-1:0] remain;
    logic                   running;
    logic                   finished;
    logic                   blank;
  } disp_state_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'hC0;
      4'd1: seg = 8'hF9;
      4'd2: seg = 8'hA4;
      4'd3: seg = 8'hB0;
      4'd4: seg = 8'h99;
      4'd5: seg = 8'h92;
      4'd6: seg = 8'h82;
      4'd7: seg = 8'hF8;
      4'd8: seg = 8'h80;
      4'd9: seg = 8'h90;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // Rounded-up 2^28 / 10^(k+1); the thousands digit sits at scan position 0.
  function automatic logic [RecipWidth-1:0] recip_of(input logic [1:0] pos);
    logic [RecipWidth-1:0] r;
    case (pos)
      2'd0: r = 25'd26844;
      2'd1: r = 25'd268436;
      2'd2: r = 25'd2684355;
      2'd3: r = 25'd26843546;
      default: r = 25'd26843546;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/countdown_timer_with_display.sv =====
// Countdown timer with a scanned four-digit seven-segment display.
// A tick's state update is registered in the state registers at its transfer, and
// its display word is then registered in the output register, which can stall.
// One tick per cycle while the output is not stalled; state update and digit
// extraction (one 14x25 multiply) each take one register stage.
// Reset (rst, synchronous) clears counters and flags and loads register defaults.
module countdown_timer_with_display
  import cdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_up_level, key_down_level, key_start_level, then zero fill
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // segments, digit_select, remaining_seconds, is_running, is_finished, zero fill
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  logic [3:0]             ticks_per_key_sample;
  logic [7:0]             ticks_per_step;
  logic [7:0]             steps_per_second;
  logic [7:0]             steps_per_blink;
  logic [RemainWidth-1:0] max_setting;

  logic [3:0]             sample_div, sample_div_next;
  logic [7:0]             step_div, step_div_next;
  logic [7:0]             second_div, second_div_next;
  logic [7:0]             blink_div, blink_div_next;
  logic [RemainWidth-1:0] set_sec, set_sec_next;
  logic [RemainWidth-1:0] remain_sec, remain_sec_next;
  logic                   running, running_next;
  logic                   finished, finished_next;
  logic                   blink_vis, blink_vis_next;
  logic [2:0]             keys_held, keys_held_next;
  logic [1:0]             disp_pos;
  logic                   mid_valid;

  logic                   in_xfer;
  logic                   out_load;
  logic [2:0]             key_level;
  logic [2:0]             released;
  logic                   sample_fire;

  disp_state_t            disp;
  logic [ProdWidth-1:0]   prod;
  logic [RecipShift-1:0]  frac;
  logic [31:0]            tenx;
  logic [3:0]             digit;
  logic [7:0]             seg;

  logic [7:0]             out_segments;
  logic [3:0]             out_digit_select;
  logic [RemainWidth-1:0] out_remaining;
  logic                   out_running;
  logic                   out_finished;
  logic                   out_valid;

  assign out_load      = mid_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !mid_valid || out_load;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign key_level     = s_axis_tdata[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_key_sample <= RST_TICKS_PER_KEY_SAMPLE;
      ticks_per_step       <= RST_TICKS_PER_STEP;
      steps_per_second     <= RST_STEPS_PER_SECOND;
      steps_per_blink      <= RST_STEPS_PER_BLINK;
      max_setting          <= RST_MAX_SETTING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_KEY_SAMPLE: ticks_per_key_sample <= cfg_data[3:0];
        CFG_TICKS_PER_STEP:       ticks_per_step       <= cfg_data[7:0];
        CFG_STEPS_PER_SECOND:     steps_per_second     <= cfg_data[7:0];
        CFG_STEPS_PER_BLINK:      steps_per_blink      <= cfg_data[7:0];
        CFG_MAX_SETTING:          max_setting          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step divider and countdown first, then the key sample, as one tick.
  always_comb begin
    step_div_next   = step_div + 8'd1;
    second_div_next = second_div;
    blink_div_next  = blink_div;
    remain_sec_next = remain_sec;
    running_next    = running;
    finished_next   = finished;
    blink_vis_next  = blink_vis;
    set_sec_next    = set_sec;

    if (step_div_next >= ticks_per_step) begin
      step_div_next = 8'd0;
      if (running) begin
        second_div_next = second_div + 8'd1;
        if (second_div_next >= steps_per_second) begin
          second_div_next = 8'd0;
          if (remain_sec != '0) begin
            remain_sec_next = remain_sec - RemainWidth'(1);
          end else begin
            running_next  = 1'b0;
            finished_next = 1'b1;
          end
        end
      end else if (finished) begin
        blink_div_next = blink_div + 8'd1;
        if (blink_div_next >= steps_per_blink) begin
          blink_div_next = 8'd0;
          blink_vis_next = !blink_vis;
        end
      end
    end

    sample_div_next = sample_div + 4'd1;
    sample_fire     = sample_div_next >= ticks_per_key_sample;
    if (sample_fire) begin
      sample_div_next = 4'd0;
    end
    released       = {3{sample_fire}} & key_level & keys_held;
    keys_held_next = sample_fire ? ~key_level : keys_held;

    if (released[0] && !running_next && !finished_next) begin
      if (set_sec_next >= max_setting) begin
        set_sec_next = max_setting;
      end else begin
        set_sec_next = set_sec_next + RemainWidth'(1);
      end
      remain_sec_next = set_sec_next;
    end
    if (released[1] && !running_next && !finished_next) begin
      if (set_sec_next != '0) begin
        set_sec_next = set_sec_next - RemainWidth'(1);
      end
      remain_sec_next = set_sec_next;
    end
    if (released[2]) begin
      if (finished_next) begin
        finished_next   = 1'b0;
        blink_vis_next  = 1'b1;
        remain_sec_next = set_sec_next;
      end
      if (remain_sec_next != '0 && !running_next) begin
        running_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_div <= '0;
      step_div   <= '0;
      second_div <= '0;
      blink_div  <= '0;
      set_sec    <= '0;
      remain_sec <= '0;
      running    <= 1'b0;
      finished   <= 1'b0;
      blink_vis  <= 1'b1;
      keys_held  <= '0;
      disp_pos   <= 2'd3;
      mid_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        sample_div <= sample_div_next;
        step_div   <= step_div_next;
        second_div <= second_div_next;
        blink_div  <= blink_div_next;
        set_sec    <= set_sec_next;
        remain_sec <= remain_sec_next;
        running    <= running_next;
        finished   <= finished_next;
        blink_vis  <= blink_vis_next;
        keys_held  <= keys_held_next;
        disp_pos   <= disp_pos + 2'd1;
      end
      if (in_xfer) begin
        mid_valid <= 1'b1;
      end else if (out_load) begin
        mid_valid <= 1'b0;
      end
    end
  end

  // The fraction of remain / 10^(k+1), times ten, gives the scanned digit.
  assign disp = '{remain: remain_sec, running: running, finished: finished,
                  blank: finished && !blink_vis};
  assign prod  = ProdWidth'(disp.remain) * ProdWidth'(recip_of(disp_pos));
  assign frac  = prod[RecipShift-1:0];
  assign tenx  = 32'({frac, 3'b000}) + 32'({frac, 1'b0});
  assign digit = tenx[RecipShift+3:RecipShift];

  always_comb begin
    if (disp.blank) begin
      seg = SEG_BLANK;
    end else if (disp.finished) begin
      seg = SEG_EIGHT;
    end else begin
      seg = seg_of(digit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_segments     <= seg;
      out_digit_select <= ~(4'd1 << disp_pos);
      out_remaining    <= disp.remain;
      out_running      <= disp.running;
      out_finished     <= disp.finished;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_finished, out_running, out_remaining,
                          out_digit_select, out_segments};

  a_run_fin_excl: assert property (@(posedge clk) disable iff (rst)
    !(running && finished))
    else $error("running and finished both set");

  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    finished |-> (remain_sec == '0))
    else $error("finished with a nonzero count");

  a_blink_idle: assert property (@(posedge clk) disable iff (rst)
    !finished |-> blink_vis)
    else $error("display blanked outside the finished state");

  a_mid_fill: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> mid_valid)
    else $error("accepted tick did not reach the display stage");

  a_digit_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(~out_digit_select))
    else $error("digit select is not one-hot");

endmodule
